// ----- src/jsc_pkg.sv -----
package jsc_pkg;

  typedef enum logic [1:0] {
    VERDICT_INCOMPLETE = 2'd0,
    VERDICT_COMPLETE   = 2'd1,
    VERDICT_INVALID    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    verdict_t verdict;
    logic     final_verdict;
    logic     nesting_overflow;
  } out_beat_t;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
  localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
  localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0D;

  // stack entry kinds
  localparam logic KIND_BRACE   = 1'b0;
  localparam logic KIND_BRACKET = 1'b1;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

endpackage

// ----- src/jsc_ram.sv -----
module jsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/json_structure_checker_unit.sv -----
// channel | ports                        | carries
// --------+------------------------------+---------------------------------
// input   | in_valid, in_ready, in_data  | text_byte, end_of_text
// output  | out_valid, out_ready, out_data | verdict, final_verdict, overflow
//
// One byte per clock unless out_ready stalls; each verdict shows in the next cycle.
// The rate is set by the single update step on the parser flags and the
// top-of-stack register; the stack below the top sits in a RAM whose
// registered read always prefetches the entry under the top.
// rst_n is synchronous; no clearing pass, the stack is only read below depth.
// in_ready is high whenever the output register is empty or being taken.
module json_structure_checker_unit #(
  parameter int MAX_NESTING = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jsc_pkg::out_beat_t out_data
);
  import jsc_pkg::*;

  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic [DW-1:0] depth_r, depth_nxt;
  logic          in_str_r, in_str_nxt;
  logic          esc_r, esc_nxt;
  logic          seen_r, seen_nxt;
  logic          closed_r, closed_nxt;
  logic          inv_r, inv_nxt;
  logic          ovf_r, ovf_nxt;
  logic          top_r, top_nxt;
  logic          byp_r, byp_nxt;
  logic          byp_val_r, byp_val_nxt;
  logic          out_valid_r;
  out_beat_t     out_data_r, out_data_nxt;

  logic          accept;
  logic          push;
  logic          below;
  logic          ram_rdata;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] depth_nxt_m2;
  logic [7:0]    b;
  logic          want;
  verdict_t      verdict;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.text_byte;
  assign want     = (b == CHAR_RBRACKET) ? KIND_BRACKET : KIND_BRACE;
  // entry under the top: just written last cycle, or prefetched from RAM
  assign below    = byp_r ? byp_val_r : ram_rdata;

  always_comb begin
    depth_nxt   = depth_r;
    in_str_nxt  = in_str_r;
    esc_nxt     = esc_r;
    seen_nxt    = seen_r;
    closed_nxt  = closed_r;
    inv_nxt     = inv_r;
    ovf_nxt     = ovf_r;
    top_nxt     = top_r;
    push        = 1'b0;
    verdict     = VERDICT_INCOMPLETE;

    if (accept && !inv_r) begin
      if (closed_r && !is_blank(b)) begin
        inv_nxt = 1'b1;
      end else if (in_str_r) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (b == CHAR_BACKSLASH) begin
          esc_nxt = 1'b1;
        end else if (b == CHAR_QUOTE) begin
          in_str_nxt = 1'b0;
        end
      end else if (b == CHAR_QUOTE) begin
        in_str_nxt = 1'b1;
        seen_nxt   = 1'b1;
      end else if (b == CHAR_LBRACE || b == CHAR_LBRACKET) begin
        if (depth_r == '0 && seen_r) begin
          inv_nxt = 1'b1;
        end else begin
          if (depth_r == '0) begin
            seen_nxt = 1'b1;
          end
          if (depth_r == DW'(MAX_NESTING)) begin
            ovf_nxt = 1'b1;
            inv_nxt = 1'b1;
          end else begin
            push      = 1'b1;
            depth_nxt = depth_r + DW'(1);
            top_nxt   = (b == CHAR_LBRACKET) ? KIND_BRACKET : KIND_BRACE;
          end
        end
      end else if (b == CHAR_RBRACE || b == CHAR_RBRACKET) begin
        if (depth_r == '0 || top_r != want) begin
          inv_nxt = 1'b1;
        end else begin
          depth_nxt = depth_r - DW'(1);
          top_nxt   = below;
          if (depth_r == DW'(1)) begin
            closed_nxt = 1'b1;
          end
        end
      end else if (!is_blank(b) && depth_r == '0) begin
        inv_nxt = 1'b1;
      end
    end

    if (inv_nxt) begin
      verdict = VERDICT_INVALID;
    end else if (in_str_nxt || esc_nxt || depth_nxt != '0) begin
      verdict = VERDICT_INCOMPLETE;
    end else if (closed_nxt) begin
      verdict = VERDICT_COMPLETE;
    end

    out_data_nxt.verdict          = verdict;
    out_data_nxt.final_verdict    = in_data.end_of_text;
    out_data_nxt.nesting_overflow = ovf_nxt;

    byp_nxt     = push;
    byp_val_nxt = top_r;

    if (accept && in_data.end_of_text) begin
      depth_nxt  = '0;
      in_str_nxt = 1'b0;
      esc_nxt    = 1'b0;
      seen_nxt   = 1'b0;
      closed_nxt = 1'b0;
      inv_nxt    = 1'b0;
      ovf_nxt    = 1'b0;
    end
  end

  assign depth_m1     = depth_r - DW'(1);
  assign depth_nxt_m2 = depth_nxt - DW'(2);

  // on a push from nonzero depth the old top goes to the RAM at depth-1
  jsc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NESTING),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (push && depth_r != '0),
    .waddr (depth_m1[AW-1:0]),
    .wdata (top_r),
    .raddr (depth_nxt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      in_str_r    <= 1'b0;
      esc_r       <= 1'b0;
      seen_r      <= 1'b0;
      closed_r    <= 1'b0;
      inv_r       <= 1'b0;
      ovf_r       <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r  <= depth_nxt;
      in_str_r <= in_str_nxt;
      esc_r    <= esc_nxt;
      seen_r   <= seen_nxt;
      closed_r <= closed_nxt;
      inv_r    <= inv_nxt;
      ovf_r    <= ovf_nxt;
      byp_r    <= byp_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    byp_val_r <= byp_val_nxt;
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/jsc_checker.sv -----
module jsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input jsc_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input jsc_pkg::out_beat_t out_data
);
  import jsc_pkg::*;

  logic inv_pending_r;

  // an invalid verdict stays until the last beat of the text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_pending_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      inv_pending_r <= (out_data.verdict == VERDICT_INVALID) && !out_data.final_verdict;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no verdict");

  a_ovf_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.nesting_overflow |-> out_data.verdict == VERDICT_INVALID)
    else $error("overflow without invalid verdict");

  a_inv_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inv_pending_r |-> out_data.verdict == VERDICT_INVALID)
    else $error("invalid verdict not sticky");

endmodule

bind json_structure_checker_unit jsc_checker u_jsc_checker (.*);
